[design/src_pkg.sv]
// Package: shared types and constants for the segment rectangle clipper.
package src_pkg;

    localparam int COORD_BITS  = 32;
    localparam int T_FRAC_BITS = 32;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int T_BITS      = T_FRAC_BITS + 1;
    localparam int MAG_BITS    = COORD_BITS;
    localparam int PROD_BITS   = DIFF_BITS + T_BITS;
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;
    localparam int NUM_TESTS   = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_right;
        logic signed [COORD_BITS-1:0] rect_bottom;
        logic signed [COORD_BITS-1:0] rect_top;
    } src_in_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] clip_start_x;
        logic signed [COORD_BITS-1:0] clip_start_y;
        logic signed [COORD_BITS-1:0] clip_end_x;
        logic signed [COORD_BITS-1:0] clip_end_y;
    } src_out_t;

    // Per-test classification carried along the divider pipeline.
    typedef struct packed {
        logic entering;
        logic leaving;
        logic need_div;
        logic reject;
        logic full;
    } src_test_t;

endpackage

[design/src_divider.sv]
// Pipelined fraction divider: one quotient bit per stage, n < d.
module src_divider
    import src_pkg::*;
(
    input  logic                 clk,
    input  logic [DIFF_BITS-1:0] num,
    input  logic [DIFF_BITS-1:0] den,
    output logic [T_FRAC_BITS-1:0] quo
);

    logic [DIFF_BITS:0]     rem_reg [T_FRAC_BITS+1];
    logic [DIFF_BITS-1:0]   den_reg [T_FRAC_BITS+1];
    logic [T_FRAC_BITS-1:0] quo_reg [T_FRAC_BITS+1];

    always_comb
    begin
        rem_reg[0] = {1'b0, num};
        den_reg[0] = den;
        quo_reg[0] = '0;
    end

    for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_stage
        logic [DIFF_BITS:0] shifted;
        logic               take;
        assign shifted = {rem_reg[i][DIFF_BITS-1:0], 1'b0};
        assign take    = shifted >= {1'b0, den_reg[i]};
        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= take ? shifted - {1'b0, den_reg[i]} : shifted;
            den_reg[i+1] <= den_reg[i];
            quo_reg[i+1] <= {quo_reg[i][T_FRAC_BITS-2:0], take};
        end
    end

    assign quo = quo_reg[T_FRAC_BITS];

endmodule

[design/segment_rect_clipper.sv]
// Top level: Liang-Barsky segment clipper against an axis-aligned rectangle.
//
// Usage: drive the segment and rectangle on in_item and raise start. busy is
// always low, so an item is taken at every edge where start is high; a new
// item may follow in each cycle. Each item yields exactly one result on
// out_item, shown for one cycle with done high; the receiver must take it.
// Pipeline: a register for differences and test setup, the bit-per-stage
// divider (four in parallel), the stages that narrow t0/t1 one boundary test
// per stage, a register to pick magnitudes, a register for the products and
// a register for rounding and the output. Throughput is one item per cycle,
// set by the divider stages. Reset clears the valid bits only; payload is not
// reset. A rejected segment gives hit low and all coordinates zero.
module segment_rect_clipper
    import src_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  src_in_t  in_item,
    output logic     done,
    output src_out_t out_item
);

    localparam int DIV_LAT = T_FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x0;
        logic signed [COORD_BITS-1:0] y0;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
    } geo_t;

    assign busy = 1'b0;

    // Stage 1: differences and classification.
    logic                valid_s1_reg;
    geo_t                geo_s1_reg;
    src_test_t           cls_s1_reg [NUM_TESTS];
    logic [DIFF_BITS-1:0] num_s1_reg [NUM_TESTS];
    logic [DIFF_BITS-1:0] den_s1_reg [NUM_TESTS];

    logic signed [DIFF_BITS-1:0] p_c [NUM_TESTS];
    logic signed [DIFF_BITS-1:0] q_c [NUM_TESTS];
    logic signed [DIFF_BITS-1:0] dx_c, dy_c;

    always_comb
    begin
        dx_c = DIFF_BITS'(in_item.end_x) - DIFF_BITS'(in_item.start_x);
        dy_c = DIFF_BITS'(in_item.end_y) - DIFF_BITS'(in_item.start_y);
        p_c[0] = -dx_c;
        q_c[0] = DIFF_BITS'(in_item.start_x) - DIFF_BITS'(in_item.rect_left);
        p_c[1] = dx_c;
        q_c[1] = DIFF_BITS'(in_item.rect_right) - DIFF_BITS'(in_item.start_x);
        p_c[2] = -dy_c;
        q_c[2] = DIFF_BITS'(in_item.start_y) - DIFF_BITS'(in_item.rect_bottom);
        p_c[3] = dy_c;
        q_c[3] = DIFF_BITS'(in_item.rect_top) - DIFF_BITS'(in_item.start_y);
    end

    for (genvar k = 0; k < NUM_TESTS; k++) begin : g_cls
        logic [DIFF_BITS-1:0] n_abs, d_abs;
        src_test_t            cls;
        always_comb
        begin
            n_abs = p_c[k][DIFF_BITS-1] ? DIFF_BITS'(-q_c[k]) : q_c[k];
            d_abs = p_c[k][DIFF_BITS-1] ? DIFF_BITS'(-p_c[k]) : p_c[k];
            cls   = '0;
            if (p_c[k] == '0)
            begin
                cls.reject = q_c[k][DIFF_BITS-1];
            end
            else if (p_c[k][DIFF_BITS-1])
            begin
                // entering: num = -q; no effect unless positive
                if (!q_c[k][DIFF_BITS-1] || q_c[k] == '0)
                    cls = '0;
                else if (n_abs > d_abs)
                    cls.reject = 1'b1;
                else
                begin
                    cls.entering = 1'b1;
                    cls.full     = n_abs == d_abs;
                    cls.need_div = n_abs != d_abs;
                end
            end
            else
            begin
                if (q_c[k][DIFF_BITS-1])
                    cls.reject = 1'b1;
                else if (n_abs < d_abs)
                begin
                    cls.leaving  = 1'b1;
                    cls.need_div = 1'b1;
                end
            end
        end
        always_ff @(posedge clk)
        begin
            cls_s1_reg[k] <= cls;
            num_s1_reg[k] <= cls.need_div ? n_abs : '0;
            den_s1_reg[k] <= cls.need_div ? d_abs : DIFF_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        geo_s1_reg.x0 <= in_item.start_x;
        geo_s1_reg.y0 <= in_item.start_y;
        geo_s1_reg.dx <= dx_c;
        geo_s1_reg.dy <= dy_c;
    end

    // Divider pipelines with matching delay lines.
    logic [T_FRAC_BITS-1:0] quo_c [NUM_TESTS];
    for (genvar k = 0; k < NUM_TESTS; k++) begin : g_div
        src_divider u_div (
            .clk (clk),
            .num (num_s1_reg[k]),
            .den (den_s1_reg[k]),
            .quo (quo_c[k])
        );
    end

    logic      valid_d_reg [DIV_LAT+1];
    geo_t      geo_d_reg   [DIV_LAT+1];
    src_test_t cls_d_reg   [DIV_LAT+1][NUM_TESTS];

    always_comb
    begin
        valid_d_reg[0] = valid_s1_reg;
        geo_d_reg[0]   = geo_s1_reg;
        cls_d_reg[0]   = cls_s1_reg;
    end

    for (genvar i = 0; i < DIV_LAT; i++) begin : g_delay
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_d_reg[i+1] <= 1'b0;
            else
                valid_d_reg[i+1] <= valid_d_reg[i];
        end
        always_ff @(posedge clk)
        begin
            geo_d_reg[i+1] <= geo_d_reg[i];
            cls_d_reg[i+1] <= cls_d_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_s1_reg <= 1'b0;
        else
            valid_s1_reg <= start;
    end

    // Narrowing stages: one boundary test per stage.
    logic [T_BITS-1:0] rat_c [NUM_TESTS];
    for (genvar k = 0; k < NUM_TESTS; k++) begin : g_rat
        assign rat_c[k] = cls_d_reg[DIV_LAT][k].full ? T_ONE
                                                     : T_BITS'(quo_c[k]);
    end

    logic              valid_n_reg [NUM_TESTS+1];
    logic              ok_n_reg    [NUM_TESTS+1];
    logic [T_BITS-1:0] t0_n_reg    [NUM_TESTS+1];
    logic [T_BITS-1:0] t1_n_reg    [NUM_TESTS+1];
    geo_t              geo_n_reg   [NUM_TESTS+1];
    src_test_t         cls_n_reg   [NUM_TESTS+1][NUM_TESTS];
    logic [T_BITS-1:0] rat_n_reg   [NUM_TESTS+1][NUM_TESTS];

    always_comb
    begin
        valid_n_reg[0] = valid_d_reg[DIV_LAT];
        ok_n_reg[0]    = 1'b1;
        t0_n_reg[0]    = '0;
        t1_n_reg[0]    = T_ONE;
        geo_n_reg[0]   = geo_d_reg[DIV_LAT];
        cls_n_reg[0]   = cls_d_reg[DIV_LAT];
        rat_n_reg[0]   = rat_c;
    end

    for (genvar i = 0; i < NUM_TESTS; i++) begin : g_narrow
        src_test_t         c;
        logic [T_BITS-1:0] r;
        logic              ok_next;
        logic [T_BITS-1:0] t0_next, t1_next;
        always_comb
        begin
            c       = cls_n_reg[i][i];
            r       = rat_n_reg[i][i];
            ok_next = ok_n_reg[i];
            t0_next = t0_n_reg[i];
            t1_next = t1_n_reg[i];
            if (c.reject)
                ok_next = 1'b0;
            else if (c.entering)
            begin
                if (r > t1_n_reg[i])
                    ok_next = 1'b0;
                else if (r > t0_n_reg[i])
                    t0_next = r;
            end
            else if (c.leaving)
            begin
                if (r < t0_n_reg[i])
                    ok_next = 1'b0;
                else if (r < t1_n_reg[i])
                    t1_next = r;
            end
            if (!ok_n_reg[i])
            begin
                t0_next = t0_n_reg[i];
                t1_next = t1_n_reg[i];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_n_reg[i+1] <= 1'b0;
            else
                valid_n_reg[i+1] <= valid_n_reg[i];
        end
        always_ff @(posedge clk)
        begin
            ok_n_reg[i+1]  <= ok_next;
            t0_n_reg[i+1]  <= t0_next;
            t1_n_reg[i+1]  <= t1_next;
            geo_n_reg[i+1] <= geo_n_reg[i];
            cls_n_reg[i+1] <= cls_n_reg[i];
            rat_n_reg[i+1] <= rat_n_reg[i];
        end
    end

    // Magnitude stage.
    logic                 valid_m_reg, hit_m_reg;
    logic [T_BITS-1:0]    t0_m_reg, t1_m_reg;
    logic [DIFF_BITS-1:0] mx_m_reg, my_m_reg;
    logic                 sx_m_reg, sy_m_reg;
    logic signed [COORD_BITS-1:0] x0_m_reg, y0_m_reg;

    geo_t g_fin;
    assign g_fin = geo_n_reg[NUM_TESTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_m_reg <= 1'b0;
        else
            valid_m_reg <= valid_n_reg[NUM_TESTS];
    end

    always_ff @(posedge clk)
    begin
        hit_m_reg <= ok_n_reg[NUM_TESTS] &&
                     !(t1_n_reg[NUM_TESTS] < t0_n_reg[NUM_TESTS]);
        t0_m_reg  <= t0_n_reg[NUM_TESTS];
        t1_m_reg  <= t1_n_reg[NUM_TESTS];
        sx_m_reg  <= g_fin.dx[DIFF_BITS-1];
        sy_m_reg  <= g_fin.dy[DIFF_BITS-1];
        mx_m_reg  <= g_fin.dx[DIFF_BITS-1] ? DIFF_BITS'(-g_fin.dx) : g_fin.dx;
        my_m_reg  <= g_fin.dy[DIFF_BITS-1] ? DIFF_BITS'(-g_fin.dy) : g_fin.dy;
        x0_m_reg  <= g_fin.x0;
        y0_m_reg  <= g_fin.y0;
    end

    // Product stage.
    logic                 valid_p_reg, hit_p_reg, sx_p_reg, sy_p_reg;
    logic [PROD_BITS-1:0] psx_reg, psy_reg, pex_reg, pey_reg;
    logic signed [COORD_BITS-1:0] x0_p_reg, y0_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_p_reg <= 1'b0;
        else
            valid_p_reg <= valid_m_reg;
    end

    always_ff @(posedge clk)
    begin
        hit_p_reg <= hit_m_reg;
        sx_p_reg  <= sx_m_reg;
        sy_p_reg  <= sy_m_reg;
        x0_p_reg  <= x0_m_reg;
        y0_p_reg  <= y0_m_reg;
        psx_reg   <= PROD_BITS'(mx_m_reg) * PROD_BITS'(t0_m_reg);
        psy_reg   <= PROD_BITS'(my_m_reg) * PROD_BITS'(t0_m_reg);
        pex_reg   <= PROD_BITS'(mx_m_reg) * PROD_BITS'(t1_m_reg);
        pey_reg   <= PROD_BITS'(my_m_reg) * PROD_BITS'(t1_m_reg);
    end

    // Rounding and output register.
    localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (T_FRAC_BITS - 1);

    function automatic logic [COORD_BITS-1:0] point(
        input logic signed [COORD_BITS-1:0] base,
        input logic                         neg,
        input logic [PROD_BITS-1:0]         prod
    );
        logic [PROD_BITS-1:0]  rnd;
        logic [COORD_BITS-1:0] off;
        rnd = (prod + HALF) >> T_FRAC_BITS;
        off = rnd[COORD_BITS-1:0];
        return neg ? base - off : base + off;
    endfunction

    logic     done_reg;
    src_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_p_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg.hit <= hit_p_reg;
        if (hit_p_reg)
        begin
            out_reg.clip_start_x <= point(x0_p_reg, sx_p_reg, psx_reg);
            out_reg.clip_start_y <= point(y0_p_reg, sy_p_reg, psy_reg);
            out_reg.clip_end_x   <= point(x0_p_reg, sx_p_reg, pex_reg);
            out_reg.clip_end_y   <= point(y0_p_reg, sy_p_reg, pey_reg);
        end
        else
        begin
            out_reg.clip_start_x <= '0;
            out_reg.clip_start_y <= '0;
            out_reg.clip_end_x   <= '0;
            out_reg.clip_end_y   <= '0;
        end
    end

    assign done     = done_reg;
    assign out_item = out_reg;

endmodule
